### sv/tsc_pkg.sv
// Shared types and constants for the triangle setup and cull block.
// Depends on nothing; every other source file but tsc_checker refers to it by scoped names.
package tsc_pkg;

  localparam int COORD_W     = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] OUTCODE_ALL = 6'h3F;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VIEWPORT_X   = 3'd0,
    CFG_VIEWPORT_Y   = 3'd1,
    CFG_VIEWPORT_Z   = 3'd2,
    CFG_GUARD_MIN    = 3'd3,
    CFG_GUARD_MAX    = 3'd4,
    CFG_FRAME_WIDTH  = 3'd5,
    CFG_FRAME_HEIGHT = 3'd6
  } cfg_index_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_RND,
    B_DIFF,
    B_AMUL1,
    B_AMUL2,
    B_ASUB,
    B_EMIT,
    B_SUM
  } back_state_t;

  // One classified triangle waiting between front and back.
  typedef struct packed {
    logic [8:0][COORD_W-1:0] coords;
    logic                    eob;
    logic                    cull;
  } tri_entry_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
  } guard_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] vp_x;
    logic [CFG_DATA_W-1:0] vp_y;
    logic [CFG_DATA_W-1:0] vp_z;
    logic [15:0]           fw;
    logic [15:0]           fh;
  } back_cfg_t;

endpackage

### sv/tsc_channels.sv
// Channel interfaces: triangle input, result output and register writes.
// Depends on tsc_pkg for field widths.
interface tsc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsc_pkg::COORD_W-1:0]  ax, ay, az, bx, by, bz, cx, cy, cz;
  logic                                end_of_batch;
  modport source(output valid, ax, ay, az, bx, by, bz, cx, cy, cz, end_of_batch,
                 input ready);
  modport sink(input valid, ax, ay, az, bx, by, bz, cx, cy, cz, end_of_batch,
               output ready);
endinterface

interface tsc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [tsc_pkg::COORD_W-1:0]  screen_x, screen_y, screen_z;
  logic                                last;
  logic signed [tsc_pkg::COORD_W-1:0]  box_min_x, box_min_y, box_max_x, box_max_y;
  logic [15:0]                         kept_count;
  modport source(output valid, kind, screen_x, screen_y, screen_z, last,
                 box_min_x, box_min_y, box_max_x, box_max_y, kept_count,
                 input ready);
  modport sink(input valid, kind, screen_x, screen_y, screen_z, last,
               box_min_x, box_min_y, box_max_x, box_max_y, kept_count,
               output ready);
endinterface

interface tsc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tsc_pkg::CFG_INDEX_W-1:0]    index;
  logic [tsc_pkg::CFG_DATA_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/triangle_setup_cull.sv
// Top level of the triangle setup and cull block: register file, front end,
// queue and back end. Depends on tsc_pkg, tsc_channels, tsc_front, tsc_queue, tsc_back.
//
//  channel    role    carries
//  vertices   sink    one triangle: ax..cz, end_of_batch
//  results    source  vertex results and batch summaries
//  cfg        sink    register writes: index, data
//
// Front accepts a triangle whenever the two-entry queue has room.
// Back: a rejected triangle is retired from the idle state; a kept one passes
// through the one shared 33x33 multiplier (transform, then the two area
// products), then emits its results. A summary result ends each batch.
// Reset is synchronous and clears the queue, sequencer, box and count.
// Either side may stall; the output register holds a result until taken.
module triangle_setup_cull #(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  tsc_in_if.sink    vertices,
  tsc_out_if.source results,
  tsc_cfg_if.sink   cfg
);
  tsc_pkg::guard_t     guard;
  tsc_pkg::back_cfg_t  bcfg;
  tsc_pkg::tri_entry_t entry;
  tsc_pkg::tri_entry_t head;
  logic                push, full, pop, empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bcfg.vp_x <= '0;
      bcfg.vp_y <= '0;
      bcfg.vp_z <= '0;
      guard.lo  <= 32'sh8000_0000;
      guard.hi  <= 32'sh7FFF_FFFF;
      bcfg.fw   <= '0;
      bcfg.fh   <= '0;
    end else if (cfg.valid) begin
      unique case (tsc_pkg::cfg_index_t'(cfg.index))
        tsc_pkg::CFG_VIEWPORT_X:   bcfg.vp_x <= cfg.data;
        tsc_pkg::CFG_VIEWPORT_Y:   bcfg.vp_y <= cfg.data;
        tsc_pkg::CFG_VIEWPORT_Z:   bcfg.vp_z <= cfg.data;
        tsc_pkg::CFG_GUARD_MIN:    guard.lo  <= cfg.data[31:0];
        tsc_pkg::CFG_GUARD_MAX:    guard.hi  <= cfg.data[31:0];
        tsc_pkg::CFG_FRAME_WIDTH:  bcfg.fw   <= cfg.data[15:0];
        tsc_pkg::CFG_FRAME_HEIGHT: bcfg.fh   <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  tsc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .vin   (vertices),
    .guard (guard),
    .full  (full),
    .push  (push),
    .entry (entry)
  );

  tsc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .full  (full),
    .pop   (pop),
    .head  (head),
    .empty (empty)
  );

  tsc_back #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .cfg   (bcfg),
    .res   (results)
  );
endmodule

### sv/tsc_queue.sv
// Short queue of classified triangles between front and back.
// Depends on tsc_pkg (tri_entry_t, QUEUE_DEPTH).
module tsc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tsc_pkg::tri_entry_t din,
  output logic                full,
  input  logic                pop,
  output tsc_pkg::tri_entry_t head,
  output logic                empty
);
  localparam int AW = (tsc_pkg::QUEUE_DEPTH > 1) ? $clog2(tsc_pkg::QUEUE_DEPTH) : 1;

  tsc_pkg::tri_entry_t slots [tsc_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(tsc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(tsc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(tsc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

### sv/tsc_front.sv
// Front end: accept triangles, compute outcodes and guard band reject.
// Depends on tsc_pkg and tsc_in_if; feeds tsc_queue.
module tsc_front #(
  parameter int FRAC_BITS = 16
) (
  tsc_in_if.sink              vin,
  input  tsc_pkg::guard_t     guard,
  input  logic                full,
  output logic                push,
  output tsc_pkg::tri_entry_t entry
);
  localparam logic signed [32:0] ONE     = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [32:0] NEG_ONE = -ONE;

  logic signed [31:0] coord [9];
  logic signed [32:0] cw;
  logic [5:0]         oc;
  logic [5:0]         gc;
  logic [5:0]         and_codes;
  logic [5:0]         or_codes;

  assign vin.ready = !full;
  assign push      = vin.valid && !full;

  always_comb begin
    coord[0] = vin.ax; coord[1] = vin.ay; coord[2] = vin.az;
    coord[3] = vin.bx; coord[4] = vin.by; coord[5] = vin.bz;
    coord[6] = vin.cx; coord[7] = vin.cy; coord[8] = vin.cz;
  end

  // Reject when all vertices sit beyond one plane, or any leaves the guard band.
  always_comb begin
    and_codes = tsc_pkg::OUTCODE_ALL;
    or_codes  = '0;
    oc        = '0;
    gc        = '0;
    cw        = '0;
    for (int i = 0; i < 3; i++) begin
      oc = '0;
      gc = '0;
      for (int a = 0; a < 3; a++) begin
        cw          = {coord[i*3+a][31], coord[i*3+a]};
        oc[2*a]     = cw < NEG_ONE;
        oc[2*a+1]   = cw > ONE;
        gc[2*a]     = coord[i*3+a] < guard.lo;
        gc[2*a+1]   = coord[i*3+a] > guard.hi;
      end
      and_codes = and_codes & oc;
      or_codes  = or_codes | gc;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      entry.coords[k] = coord[k];
    end
    entry.eob  = vin.end_of_batch;
    entry.cull = (and_codes != '0) || (or_codes != '0);
  end
endmodule

### sv/tsc_back.sv
// Back end: viewport transform on a shared multiplier, bounding box, exact
// area, winding fix and result emission. Depends on tsc_pkg and tsc_out_if.
module tsc_back #(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tsc_pkg::tri_entry_t head,
  input  logic                empty,
  output logic                pop,
  input  tsc_pkg::back_cfg_t  cfg,
  tsc_out_if.source           res
);
  localparam logic signed [65:0] RND_BIAS = (66'sd1 <<< (2 * FRAC_BITS)) - 66'sd1;
  localparam logic signed [65:0] S32_MAX  = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN  = -66'sd2147483648;

  tsc_pkg::back_state_t state, state_next;

  logic [3:0]              idx;
  logic [1:0]              axis;
  logic [1:0]              ecnt;
  logic                    fresh;
  logic signed [31:0]      s [9];
  logic signed [65:0]      prod;
  logic signed [65:0]      acc;
  logic signed [65:0]      p1;
  logic signed [32:0]      d1x, d1y, d2x, d2y;
  logic                    area_neg;
  logic signed [31:0]      min_x, min_y, max_x, max_y;
  logic [COUNT_WIDTH-1:0]  kept;

  logic                    ov;
  logic                    o_kind, o_last;
  logic signed [31:0]      o_sx, o_sy, o_sz, o_bx0, o_by0, o_bx1, o_by1;
  logic [15:0]             o_cnt;

  logic                    load;
  logic                    fire;
  logic signed [32:0]      mul_a, mul_b;
  logic [63:0]             vp_sel;
  logic signed [31:0]      scale, offs;
  logic signed [31:0]      coord_sel;
  logic signed [65:0]      rnd;
  logic signed [65:0]      q;
  logic signed [31:0]      tv;
  logic signed [66:0]      area_diff;
  logic                    area_zero;
  logic [1:0]              vsel;
  logic signed [31:0]      ex, ey, ez;
  logic [15:0]             kept_cap;

  assign res.valid      = ov;
  assign res.kind       = o_kind;
  assign res.screen_x   = o_sx;
  assign res.screen_y   = o_sy;
  assign res.screen_z   = o_sz;
  assign res.last       = o_last;
  assign res.box_min_x  = o_bx0;
  assign res.box_min_y  = o_by0;
  assign res.box_max_x  = o_bx1;
  assign res.box_max_y  = o_by1;
  assign res.kept_count = o_cnt;

  // A new result enters the output register this cycle.
  assign fire = load && ((state == tsc_pkg::B_EMIT) || (state == tsc_pkg::B_SUM));

  // Datapath decodes.
  always_comb begin
    case (axis)
      2'd0:    vp_sel = cfg.vp_x;
      2'd1:    vp_sel = cfg.vp_y;
      default: vp_sel = cfg.vp_z;
    endcase
    scale     = vp_sel[63:32];
    offs      = vp_sel[31:0];
    coord_sel = head.coords[idx];
    // Truncate toward zero, then clamp to 32 bits.
    rnd       = acc + (acc[65] ? RND_BIAS : 66'sd0);
    q         = rnd >>> (2 * FRAC_BITS);
    if (q > S32_MAX) begin
      tv = S32_MAX[31:0];
    end else if (q < S32_MIN) begin
      tv = S32_MIN[31:0];
    end else begin
      tv = q[31:0];
    end
    area_diff = {p1[65], p1} - {prod[65], prod};
    area_zero = (area_diff == '0);
    case (ecnt)
      2'd0:    vsel = area_neg ? 2'd1 : 2'd0;
      2'd1:    vsel = area_neg ? 2'd0 : 2'd1;
      default: vsel = 2'd2;
    endcase
    case (vsel)
      2'd0:    begin ex = s[0]; ey = s[1]; ez = s[2]; end
      2'd1:    begin ex = s[3]; ey = s[4]; ez = s[5]; end
      default: begin ex = s[6]; ey = s[7]; ez = s[8]; end
    endcase
    kept_cap = (kept > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF : 16'(kept);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tsc_pkg::B_IDLE: begin
        if (!empty) begin
          if (head.cull) begin
            state_next = head.eob ? tsc_pkg::B_SUM : tsc_pkg::B_IDLE;
          end else begin
            state_next = tsc_pkg::B_MUL;
          end
        end
      end
      tsc_pkg::B_MUL:   state_next = tsc_pkg::B_ADD;
      tsc_pkg::B_ADD:   state_next = tsc_pkg::B_RND;
      tsc_pkg::B_RND:   state_next = (idx == 4'd8) ? tsc_pkg::B_DIFF : tsc_pkg::B_MUL;
      tsc_pkg::B_DIFF:  state_next = tsc_pkg::B_AMUL1;
      tsc_pkg::B_AMUL1: state_next = tsc_pkg::B_AMUL2;
      tsc_pkg::B_AMUL2: state_next = tsc_pkg::B_ASUB;
      tsc_pkg::B_ASUB: begin
        if (area_zero) begin
          state_next = head.eob ? tsc_pkg::B_SUM : tsc_pkg::B_IDLE;
        end else begin
          state_next = tsc_pkg::B_EMIT;
        end
      end
      tsc_pkg::B_EMIT: begin
        if (load && ecnt == 2'd2) begin
          state_next = head.eob ? tsc_pkg::B_SUM : tsc_pkg::B_IDLE;
        end
      end
      tsc_pkg::B_SUM: begin
        if (load) begin
          state_next = tsc_pkg::B_IDLE;
        end
      end
      default: state_next = tsc_pkg::B_IDLE;
    endcase
  end

  // Control outputs: multiplier operands and queue pop.
  always_comb begin
    load  = !ov || res.ready;
    pop   = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      tsc_pkg::B_IDLE: pop = !empty && head.cull && !head.eob;
      tsc_pkg::B_MUL: begin
        mul_a = {coord_sel[31], coord_sel};
        mul_b = {scale[31], scale};
      end
      tsc_pkg::B_AMUL1: begin
        mul_a = d1x;
        mul_b = d2y;
      end
      tsc_pkg::B_AMUL2: begin
        mul_a = d2x;
        mul_b = d1y;
      end
      tsc_pkg::B_ASUB: pop = area_zero && !head.eob;
      tsc_pkg::B_EMIT: pop = load && ecnt == 2'd2 && !head.eob;
      tsc_pkg::B_SUM:  pop = load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      tsc_pkg::B_ADD: acc <= prod + ($signed({{34{offs[31]}}, offs}) <<< FRAC_BITS);
      tsc_pkg::B_RND: s[idx] <= tv;
      tsc_pkg::B_DIFF: begin
        d1x <= {s[3][31], s[3]} - {s[0][31], s[0]};
        d1y <= {s[4][31], s[4]} - {s[1][31], s[1]};
        d2x <= {s[6][31], s[6]} - {s[0][31], s[0]};
        d2y <= {s[7][31], s[7]} - {s[1][31], s[1]};
      end
      tsc_pkg::B_AMUL2: p1 <= prod;
      tsc_pkg::B_ASUB: area_neg <= area_diff[66];
      default: ;
    endcase
  end

  // Sequencing counters, batch state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      axis  <= '0;
      ecnt  <= '0;
      fresh <= 1'b1;
      min_x <= '0;
      min_y <= '0;
      max_x <= '0;
      max_y <= '0;
      kept  <= '0;
      ov    <= 1'b0;
    end else begin
      if (ov && res.ready && !fire) begin
        ov <= 1'b0;
      end
      unique case (state)
        tsc_pkg::B_IDLE: begin
          idx  <= '0;
          axis <= '0;
          ecnt <= '0;
          if (!empty && fresh) begin
            min_x <= {16'd0, cfg.fw};
            min_y <= {16'd0, cfg.fh};
            max_x <= '0;
            max_y <= '0;
            kept  <= '0;
            fresh <= 1'b0;
          end
        end
        tsc_pkg::B_RND: begin
          if (axis == 2'd0) begin
            if (tv < min_x) min_x <= tv;
            if (tv > max_x) max_x <= tv;
          end else if (axis == 2'd1) begin
            if (tv < min_y) min_y <= tv;
            if (tv > max_y) max_y <= tv;
          end
          idx  <= idx + 1'b1;
          axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
        end
        tsc_pkg::B_ASUB: begin
          if (!area_zero && kept != {COUNT_WIDTH{1'b1}}) begin
            kept <= kept + 1'b1;
          end
        end
        tsc_pkg::B_EMIT: begin
          if (load) begin
            ov     <= 1'b1;
            o_kind <= 1'b0;
            o_sx   <= ex;
            o_sy   <= ey;
            o_sz   <= ez;
            o_last <= (ecnt == 2'd2) && !head.eob;
            o_bx0  <= '0;
            o_by0  <= '0;
            o_bx1  <= '0;
            o_by1  <= '0;
            o_cnt  <= '0;
            ecnt   <= ecnt + 1'b1;
          end
        end
        tsc_pkg::B_SUM: begin
          if (load) begin
            ov     <= 1'b1;
            o_kind <= 1'b1;
            o_sx   <= '0;
            o_sy   <= '0;
            o_sz   <= '0;
            o_last <= 1'b1;
            o_bx0  <= min_x;
            o_by0  <= min_y;
            o_bx1  <= max_x;
            o_by1  <= max_y;
            o_cnt  <= kept_cap;
            min_x  <= {16'd0, cfg.fw};
            min_y  <= {16'd0, cfg.fh};
            max_x  <= '0;
            max_y  <= '0;
            kept   <= '0;
            fresh  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### sv/tsc_checker.sv
// Port-level checks on the result channel of triangle_setup_cull.
// Depends on nothing but the top level's ports; attached by bind below.
module tsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        o_valid,
  input logic        o_ready,
  input logic        o_kind,
  input logic        o_last,
  input logic [31:0] o_sx,
  input logic [31:0] o_sy,
  input logic [31:0] o_sz,
  input logic [31:0] o_bx0,
  input logic [31:0] o_by1,
  input logic [15:0] o_cnt
);
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_kind |-> o_last)
    else $error("summary result without last");

  a_vertex_no_box: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_kind |-> o_bx0 == 32'd0 && o_by1 == 32'd0 && o_cnt == 16'd0)
    else $error("vertex result carries box fields");

  a_summary_no_vertex: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_kind |-> o_sx == 32'd0 && o_sy == 32'd0 && o_sz == 32'd0)
    else $error("summary result carries vertex fields");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(o_sx) && $stable(o_kind))
    else $error("stalled result changed");
endmodule

bind triangle_setup_cull tsc_checker u_tsc_checker (
  .clk     (clk),
  .rst     (rst),
  .o_valid (results.valid),
  .o_ready (results.ready),
  .o_kind  (results.kind),
  .o_last  (results.last),
  .o_sx    (results.screen_x),
  .o_sy    (results.screen_y),
  .o_sz    (results.screen_z),
  .o_bx0   (results.box_min_x),
  .o_by1   (results.box_max_y),
  .o_cnt   (results.kept_count)
);

### verif/triangle_setup_cull_tb.sv
`timescale 1ns / 1ps
// Testbench for triangle_setup_cull: directed triangles, then random batches,
// checked against an in-bench predictor. Depends on tsc_pkg and tsc_channels.
module triangle_setup_cull_tb;

  localparam int FRAC = 16;
  localparam int CNT_W = 16;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

  typedef struct {
    logic kind;
    logic signed [31:0] sx, sy, sz;
    logic last;
    logic signed [31:0] bx0, by0, bx1, by1;
    logic [15:0] cnt;
  } res_t;

  typedef struct {
    logic signed [31:0] c[9];
    logic eob;
  } tri_t;

  typedef struct {
    tri_t t;
    bit has_exp;
    res_t r;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  tsc_in_if  vin();
  tsc_out_if vout();
  tsc_cfg_if vcfg();

  triangle_setup_cull dut (.clk(clk), .rst(rst), .vertices(vin), .results(vout), .cfg(vcfg));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [63:0] vp[3];
  logic signed [31:0] g_lo, g_hi;
  logic [15:0] fw, fh;
  logic signed [31:0] mnx, mny, mxx, mxy;
  logic [CNT_W-1:0] kept;
  bit fresh;

  res_t pending[$];
  res_t typed_exp[$];
  int errors = 0;
  bit rx_hold = 0;
  bit calm = 0;

  function automatic logic signed [31:0] map_axis(logic signed [31:0] c, logic [63:0] r);
    logic signed [127:0] acc, mag;
    acc = $signed(c) * $signed(r[63:32]) + ($signed({{96{r[31]}}, r[31:0]}) <<< FRAC);
    mag = acc < 0 ? -acc : acc;
    mag = mag >> (2 * FRAC);
    if (acc < 0) return mag > 128'sh8000_0000 ? 32'sh8000_0000 : -mag[31:0];
    return mag > 128'sh7FFF_FFFF ? 32'sh7FFF_FFFF : mag[31:0];
  endfunction

  function automatic res_t blank();
    res_t r;
    r = '{default: '0};
    return r;
  endfunction

  task automatic predict_triangle(tri_t t);
    logic [5:0] andc, orc, oc, gc;
    logic signed [31:0] s[3][3];
    logic signed [127:0] area;
    res_t r;
    int ord[3];
    andc = tsc_pkg::OUTCODE_ALL;
    orc = '0;
    if (fresh) begin
      mnx = 32'(fw); mny = 32'(fh); mxx = '0; mxy = '0; kept = '0; fresh = 0;
    end
    for (int i = 0; i < 3; i++) begin
      oc = '0; gc = '0;
      for (int a = 0; a < 3; a++) begin
        oc[2*a] = t.c[3*i+a] < -ONE_Q;
        oc[2*a+1] = t.c[3*i+a] > ONE_Q;
        gc[2*a] = t.c[3*i+a] < g_lo;
        gc[2*a+1] = t.c[3*i+a] > g_hi;
      end
      andc &= oc;
      orc |= gc;
    end
    if (andc == '0 && orc == '0) begin
      for (int i = 0; i < 3; i++) begin
        for (int a = 0; a < 3; a++) s[i][a] = map_axis(t.c[3*i+a], vp[a]);
        if (s[i][0] < mnx) mnx = s[i][0];
        if (s[i][1] < mny) mny = s[i][1];
        if (s[i][0] > mxx) mxx = s[i][0];
        if (s[i][1] > mxy) mxy = s[i][1];
      end
      area = (128'(s[1][0]) - 128'(s[0][0])) * (128'(s[2][1]) - 128'(s[0][1]))
           - (128'(s[2][0]) - 128'(s[0][0])) * (128'(s[1][1]) - 128'(s[0][1]));
      if (area != 0) begin
        ord = area < 0 ? '{1, 0, 2} : '{0, 1, 2};
        if (kept != {CNT_W{1'b1}}) kept++;
        for (int i = 0; i < 3; i++) begin
          r = blank();
          r.sx = s[ord[i]][0]; r.sy = s[ord[i]][1]; r.sz = s[ord[i]][2];
          r.last = (i == 2) && !t.eob;
          pending.push_back(r);
        end
      end
    end
    if (t.eob) begin
      r = blank();
      r.kind = 1; r.last = 1;
      r.bx0 = mnx; r.by0 = mny; r.bx1 = mxx; r.by1 = mxy;
      r.cnt = kept;
      pending.push_back(r);
      mnx = 32'(fw); mny = 32'(fh); mxx = '0; mxy = '0; kept = '0; fresh = 1;
    end
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && vout.valid && vout.ready) begin
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d", vout.kind);
        errors++;
      end else begin
        e = pending.pop_front();
        if (typed_exp.size() != 0 && vout.kind == 1) begin
          e = typed_exp.pop_front();
        end
        check_field("kind", 32'(e.kind), 32'(vout.kind));
        check_field("screen_x", e.sx, vout.screen_x);
        check_field("screen_y", e.sy, vout.screen_y);
        check_field("screen_z", e.sz, vout.screen_z);
        check_field("last", 32'(e.last), 32'(vout.last));
        check_field("box_min_x", e.bx0, vout.box_min_x);
        check_field("box_min_y", e.by0, vout.box_min_y);
        check_field("box_max_x", e.bx1, vout.box_max_x);
        check_field("box_max_y", e.by1, vout.box_max_y);
        check_field("kept_count", 32'(e.cnt), 32'(vout.kept_count));
      end
    end
  end

  // receiver: random stall bursts, a long hold when asked
  initial begin
    int n;
    vout.ready = 0;
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        vout.ready = 0;
        @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        vout.ready = 0;
        n = $urandom_range(1, 10);
        repeat (n) @(negedge clk);
      end else begin
        vout.ready = 1;
        n = $urandom_range(1, 12);
        repeat (n) if (!rx_hold) @(negedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic cfg_write(tsc_pkg::cfg_index_t idx, logic [63:0] d);
    vcfg.valid <= 1;
    vcfg.index <= idx;
    vcfg.data <= d;
    @(posedge clk);
    while (!vcfg.ready) @(posedge clk);
    @(negedge clk);
    vcfg.valid <= 0;
    case (idx)
      tsc_pkg::CFG_VIEWPORT_X: vp[0] = d;
      tsc_pkg::CFG_VIEWPORT_Y: vp[1] = d;
      tsc_pkg::CFG_VIEWPORT_Z: vp[2] = d;
      tsc_pkg::CFG_GUARD_MIN: g_lo = d[31:0];
      tsc_pkg::CFG_GUARD_MAX: g_hi = d[31:0];
      tsc_pkg::CFG_FRAME_WIDTH: fw = d[15:0];
      tsc_pkg::CFG_FRAME_HEIGHT: fh = d[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // wait for the block to drain; culled items leave no trace, so pad past latency
  task automatic drain();
    vin.valid <= 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // valid stays up after the request is taken; the next send or drain moves it
  task automatic send(tri_t t, bit gaps);
    int n;
    if (gaps && !calm && $urandom_range(0, 4) == 0) begin
      vin.valid <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(negedge clk);
    end
    vin.valid <= 1;
    {vin.ax, vin.ay, vin.az} <= {t.c[0], t.c[1], t.c[2]};
    {vin.bx, vin.by, vin.bz} <= {t.c[3], t.c[4], t.c[5]};
    {vin.cx, vin.cy, vin.cz} <= {t.c[6], t.c[7], t.c[8]};
    vin.end_of_batch <= t.eob;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    predict_triangle(t);
    @(negedge clk);
  endtask

  function automatic tri_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                              int c0, int c1, int c2, bit e);
    tri_t t;
    t.c = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    t.eob = e;
    return t;
  endfunction

  // random triangle: mostly in view, sometimes fully random or all just beyond the positive planes
  function automatic tri_t rand_tri(bit e);
    tri_t t;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 7) t.c[i] = $signed($urandom_range(0, 2 * 65536)) - 65536;
      else if (mode < 9) t.c[i] = $urandom;
      else t.c[i] = 32'sh0001_0000 + $urandom_range(1, 1000);
    end
    t.eob = e;
    return t;
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    res_t s;
    int M;
    M = 32'sh8000_0000;
    vin.valid = 0;
    {vin.ax, vin.ay, vin.az, vin.bx, vin.by, vin.bz, vin.cx, vin.cy, vin.cz} = '0;
    vin.end_of_batch = 0;
    vcfg.valid = 0; vcfg.index = '0; vcfg.data = '0;
    vp = '{64'd0, 64'd0, 64'd0};
    g_lo = 32'sh8000_0000; g_hi = 32'sh7FFF_FFFF;
    fw = '0; fh = '0;
    mnx = '0; mny = '0; mxx = '0; mxy = '0; kept = '0; fresh = 1;
    repeat (3) @(negedge clk);
    rst = 0;

    // after reset every map is zero: a zero-area triangle, summary of the reset box
    s = blank(); s.kind = 1; s.last = 1;
    rw.t = mk(0, 0, 0, 100, 0, 0, 0, 100, 0, 1); rw.has_exp = 1; rw.r = s;
    rows.push_back(rw);
    rw.has_exp = 0;
    foreach (rows[i]) begin
      if (rows[i].has_exp) typed_exp.push_back(rows[i].r);
      send(rows[i].t, 0);
    end
    drain();

    // scale 100, offset 320 on x; scale 100, offset 240 on y; z scale 1
    cfg_write(tsc_pkg::CFG_VIEWPORT_X, {32'd100 << FRAC, 32'd320 << FRAC});
    cfg_write(tsc_pkg::CFG_VIEWPORT_Y, {32'd100 << FRAC, 32'd240 << FRAC});
    cfg_write(tsc_pkg::CFG_VIEWPORT_Z, {32'd1 << FRAC, 32'd0});
    cfg_write(tsc_pkg::CFG_FRAME_WIDTH, 64'd640);
    cfg_write(tsc_pkg::CFG_FRAME_HEIGHT, 64'd480);
    rows.delete();
    // ccw, cw, degenerate, all beyond +x, all beyond -z, straddling, two with eob
    rows.push_back('{mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0), 0, blank()});
    rows.push_back('{mk(0, 0, 0, 0, 65536, 0, 65536, 0, 0, 0), 0, blank()});
    rows.push_back('{mk(0, 0, 0, 1000, 1000, 0, 2000, 2000, 0, 0), 0, blank()});
    rows.push_back('{mk(65537, 0, 0, 99999, 5, 0, 70000, -5, 0, 0), 0, blank()});
    rows.push_back('{mk(0, 0, -65537, 9, 0, -70000, 0, 9, M, 0), 0, blank()});
    rows.push_back('{mk(65537, 0, 0, -65537, 0, 0, 0, 65537, 0, 0), 0, blank()});
    rows.push_back('{mk(M, M, M, -1, -1, -1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1),
                     0, blank()});
    rows.push_back('{mk(65537, 65537, 65537, 70000, 70000, 70000, 80000, 80000, 80000, 1),
                     0, blank()});
    foreach (rows[i]) send(rows[i].t, 0);
    drain();

    // guard band tight, extreme maps to drive saturation
    cfg_write(tsc_pkg::CFG_GUARD_MIN, 64'(-32'sd32768));
    cfg_write(tsc_pkg::CFG_GUARD_MAX, 64'd32768);
    cfg_write(tsc_pkg::CFG_VIEWPORT_X, 64'h7FFF_FFFF_8000_0000);
    cfg_write(tsc_pkg::CFG_VIEWPORT_Y, 64'h8000_0000_7FFF_FFFF);
    cfg_write(tsc_pkg::CFG_VIEWPORT_Z, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(tsc_pkg::CFG_FRAME_WIDTH, 64'hFFFF);
    cfg_write(tsc_pkg::CFG_FRAME_HEIGHT, 64'd0);
    send(mk(0, 0, 0, 32768, 0, 0, 0, 32768, 7, 0), 0);
    send(mk(0, 0, 0, 32769, 0, 0, 0, 100, 0, 0), 0);
    send(mk(-32768, -32768, 1, 32768, -32768, 0, 0, 32768, 0, 1), 0);
    drain();

    // random phases with different register settings
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(tsc_pkg::CFG_VIEWPORT_X, {$urandom_range(0, 800) << FRAC, $urandom});
      cfg_write(tsc_pkg::CFG_VIEWPORT_Y,
                {32'($urandom_range(0, 800)) << 12, 32'($urandom_range(0, 1 << 24))});
      cfg_write(tsc_pkg::CFG_VIEWPORT_Z, {$urandom, $urandom});
      cfg_write(tsc_pkg::CFG_GUARD_MIN, ph == 3 ? 64'h8000_0000 : 64'(-32'sd90000));
      cfg_write(tsc_pkg::CFG_GUARD_MAX, ph == 3 ? 64'h7FFF_FFFF : 64'd90000);
      cfg_write(tsc_pkg::CFG_FRAME_WIDTH, 64'($urandom_range(0, 65535)));
      cfg_write(tsc_pkg::CFG_FRAME_HEIGHT, 64'($urandom_range(0, 65535)));
      if (ph == 1) rx_hold = 1;
      if (ph == 3) calm = 1;
      for (int k = 0; k < 25; k++) begin
        if (ph == 2 && k == 12) begin
          vin.valid <= 0;
          while (pending.size() != 0) @(negedge clk);
        end
        send(rand_tri($urandom_range(0, 5) == 0 || k == 24), 1);
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // long receiver hold: count it here so the sender keeps offering
  initial begin
    @(posedge rx_hold);
    repeat (300) @(negedge clk);
    rx_hold = 0;
  end
endmodule

### files.f
sv/tsc_pkg.sv
sv/tsc_channels.sv
sv/tsc_queue.sv
sv/tsc_front.sv
sv/tsc_back.sv
sv/triangle_setup_cull.sv
sv/tsc_checker.sv
verif/triangle_setup_cull_tb.sv
